>>> src/vario_climb_tone_select_defines.svh
// Assertion macros shared by the variometer tone selector sources.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef VARIO_CLIMB_TONE_SELECT_DEFINES_SVH
`define VARIO_CLIMB_TONE_SELECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VCT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VCT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vct_pkg.sv
// Package for the variometer tone selector: field widths, reset values, codes and types.
// Used by vct_table, vct_muldiv and vario_climb_tone_select; depends on nothing.
`timescale 1ns / 1ps

package vct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

    localparam int VEL_W    = 12;
    localparam int SENS_W   = 9;
    localparam int VOL_W    = 7;
    localparam int IDX_W    = 4;
    localparam int FREQ_W   = 15;
    localparam int PERIOD_W = 13;
    localparam int DUTY_W   = 7;
    localparam int MODE_W   = 2;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 12;

    localparam logic [CFG_IW-1:0] CFG_SINK  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_CLIMB = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_SENS  = 2'd2;

    localparam logic signed [VEL_W-1:0] SINK_RESET  = -12'sd300;
    localparam logic signed [VEL_W-1:0] CLIMB_RESET = 12'sd20;
    localparam logic [SENS_W-1:0]       SENS_RESET  = 9'd10;

    // Shared multiply-divide unit: quotient bits, operand width, product width.
    localparam int MD_QW    = 15;
    localparam int MD_MW    = 12;
    localparam int MD_PW    = MD_QW + MD_MW;
    localparam int MD_STEPS = MD_QW;
    localparam int MD_CW    = $clog2(MD_STEPS);

    localparam logic [MD_MW-1:0]    PERCENT     = 12'd100;
    localparam logic [PERIOD_W-1:0] CONT_LENGTH = 13'd100;
    localparam logic [PERIOD_W-1:0] ON_MAX      = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SILENT = 2'd0,
        MODE_SINK   = 2'd1,
        MODE_CLIMB  = 2'd2
    } t_beep_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LERP_GO,
        ST_LERP_WAIT,
        ST_ON_GO,
        ST_ON_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        FLD_FREQ,
        FLD_PERIOD,
        FLD_DUTY
    } t_field;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel;
        logic [FREQ_W-1:0]       freq;
        logic [PERIOD_W-1:0]     period;
        logic [DUTY_W-1:0]       duty;
    } t_entry;

    typedef struct packed {
        logic [MD_QW-1:0] mag;
        logic [MD_MW-1:0] mult;
        logic [MD_MW-1:0] div;
    } t_md_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MD_QW-1:0] quot;
    } t_md_stat;

endpackage

>>> src/vct_table.sv
// Tone table memory: one write port and one registered read port.
// Depends on vct_pkg for the entry type and table depth.
`timescale 1ns / 1ps

module vct_table (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [vct_pkg::TBL_AW-1:0] i_waddr,
    input  vct_pkg::t_entry          i_wdata,
    input  logic [vct_pkg::TBL_AW-1:0] i_raddr,
    output vct_pkg::t_entry          o_rdata
);
    import vct_pkg::*;

    t_entry mem [TABLE_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/vct_muldiv.sv
// Shared multiply-then-divide unit: floor(mag * mult / div), one quotient bit per cycle.
// Depends on vct_pkg and on the assertion macros in vario_climb_tone_select_defines.svh.
`timescale 1ns / 1ps
`include "vario_climb_tone_select_defines.svh"

module vct_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  vct_pkg::t_md_req  i_req,
    output vct_pkg::t_md_stat o_stat
);
    import vct_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [MD_CW-1:0]       r_cnt;
    logic [MD_PW-1:0]       r_acc;
    logic [MD_MW-1:0]       r_div;
    logic [MD_PW-1:0]       prod;
    logic [MD_MW:0]         shifted;
    logic [MD_MW+1:0]       trial;
    logic                   qbit;
    logic [MD_MW-1:0]       new_rem;

    // The caller guarantees the quotient fits in MD_QW bits, so the upper
    // part of the product is already below the divisor.
    assign prod    = MD_PW'(i_req.mag) * MD_PW'(i_req.mult);
    assign shifted = {r_acc[MD_PW-1:MD_QW], r_acc[MD_QW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_div};
    assign qbit    = ~trial[MD_MW+1];
    assign new_rem = qbit ? trial[MD_MW-1:0] : shifted[MD_MW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == MD_CW'(MD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= prod;
            r_div <= i_req.div;
        end else if (r_busy) begin
            r_acc <= {new_rem, r_acc[MD_QW-2:0], qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.quot = r_acc[MD_QW-1:0];

    `VCT_ASSERT_IMP(a_md_cnt_range, i_clk, i_rst_n, r_busy, (r_cnt < MD_CW'(MD_STEPS)), "step count out of range")
    `VCT_ASSERT_IMP(a_md_rem_below_div, i_clk, i_rst_n, r_busy, (r_acc[MD_PW-1:MD_QW] < r_div), "partial remainder not below divisor")
    `VCT_ASSERT_NXT(a_md_done_pulse, i_clk, i_rst_n, r_done, (!r_done), "done held for more than one cycle")

endmodule

>>> src/vario_climb_tone_select.sv
// Top level of the variometer tone selector: sequencer, mode hysteresis and output register.
// Depends on vct_pkg, vct_table, vct_muldiv and vario_climb_tone_select_defines.svh.
`timescale 1ns / 1ps
`include "vario_climb_tone_select_defines.svh"

// Each velocity sample updates the silent, sinking or climbing mode with hysteresis and
// returns one result; a table write returns none. A sample that leaves the block silent
// goes straight to the output register without a table search. In sinking or climbing the
// sixteen-entry table is walked one entry per cycle from a single read port; when the
// sample falls between two entries, frequency, period and duty are then interpolated one
// after the other on a shared multiply-divide unit that produces one quotient bit per
// cycle, and the on-length takes one more use of that unit. The input is stalled while a
// sample is in progress; a finished result waits in the output register while the next
// item is taken. The table must be fully written before the first sounding sample, and
// configuration is written only while the block is idle.

module vario_climb_tone_select (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_action,
    input  logic signed [vct_pkg::VEL_W-1:0]     i_velocity,
    input  logic [vct_pkg::VOL_W-1:0]            i_volume,
    input  logic [vct_pkg::IDX_W-1:0]            i_entry_index,
    input  logic signed [vct_pkg::VEL_W-1:0]     i_entry_velocity,
    input  logic [vct_pkg::FREQ_W-1:0]           i_entry_freq,
    input  logic [vct_pkg::PERIOD_W-1:0]         i_entry_period,
    input  logic [vct_pkg::DUTY_W-1:0]           i_entry_duty,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [vct_pkg::MODE_W-1:0]           o_mode,
    output logic [vct_pkg::FREQ_W-1:0]           o_tone_freq,
    output logic [vct_pkg::PERIOD_W-1:0]         o_on_length,
    output logic [vct_pkg::PERIOD_W-1:0]         o_off_length,
    output logic                                 o_continuous,
    output logic [vct_pkg::VOL_W-1:0]            o_out_volume,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [vct_pkg::CFG_IW-1:0]           i_cfg_index,
    input  logic [vct_pkg::CFG_DW-1:0]           i_cfg_data
);
    import vct_pkg::*;

    localparam logic [TBL_AW-1:0] LAST_IDX = TBL_AW'(TABLE_ENTRIES - 1);

    t_state                   r_state;
    t_state                   n_state;
    t_beep_mode               r_mode;
    t_beep_mode               n_mode;
    t_field                   r_fld;
    logic signed [VEL_W-1:0]  r_sink;
    logic signed [VEL_W-1:0]  r_climb;
    logic [SENS_W-1:0]        r_sens;

    logic signed [VEL_W-1:0]  r_vel;
    logic [VOL_W-1:0]         r_vol;
    logic [TBL_AW-1:0]        r_idx;
    t_entry                   r_prev;
    t_entry                   r_lo;
    t_entry                   r_hi;
    logic [MD_MW-1:0]         r_num;
    logic [MD_MW-1:0]         r_den;
    logic                     r_neg;
    logic [FREQ_W-1:0]        r_freq;
    logic [PERIOD_W-1:0]      r_period;
    logic [DUTY_W-1:0]        r_duty;
    logic [PERIOD_W-1:0]      r_on;
    logic [PERIOD_W-1:0]      r_off;
    logic                     r_cont;

    logic                     r_out_valid;
    t_beep_mode               r_out_mode;
    logic [FREQ_W-1:0]        r_out_freq;
    logic [PERIOD_W-1:0]      r_out_on;
    logic [PERIOD_W-1:0]      r_out_off;
    logic                     r_out_cont;
    logic [VOL_W-1:0]         r_out_vol;

    logic                     in_accept;
    logic                     cfg_accept;
    logic                     out_free;
    logic                     tbl_we;
    logic [TBL_AW-1:0]        tbl_raddr;
    t_entry                   tbl_wdata;
    t_entry                   tbl_rdata;
    logic                     hit;
    logic                     md_start;
    t_md_req                  md_req;
    t_md_stat                 md_stat;

    logic signed [VEL_W+1:0]  v_x;
    logic signed [VEL_W+1:0]  sink_x;
    logic signed [VEL_W+1:0]  climb_x;
    logic signed [VEL_W+1:0]  sens_x;
    logic                     at_sink;
    logic                     at_climb;
    logic                     change;

    logic signed [FREQ_W:0]   lerp_a;
    logic signed [FREQ_W:0]   lerp_b;
    logic signed [FREQ_W:0]   lerp_diff;
    logic signed [FREQ_W:0]   lerp_mag;
    logic signed [FREQ_W:0]   lerp_res;
    logic [FREQ_W-1:0]        on_q;
    logic [FREQ_W-1:0]        period_x;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign cfg_accept = i_cfg_valid && o_cfg_ready;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Mode hysteresis, evaluated on the incoming sample.
    assign v_x      = (VEL_W + 2)'(i_velocity);
    assign sink_x   = (VEL_W + 2)'(r_sink);
    assign climb_x  = (VEL_W + 2)'(r_climb);
    assign sens_x   = $signed((VEL_W + 2)'(r_sens));
    assign at_sink  = v_x <= sink_x;
    assign at_climb = v_x >= climb_x;

    always_comb begin
        case (r_mode)
            MODE_SINK:  change = v_x > (sink_x + sens_x);
            MODE_CLIMB: change = v_x < (climb_x - sens_x);
            default:    change = at_sink || at_climb;
        endcase
        if (!change) begin
            n_mode = r_mode;
        end else if (at_sink) begin
            n_mode = MODE_SINK;
        end else if (at_climb) begin
            n_mode = MODE_CLIMB;
        end else begin
            n_mode = MODE_SILENT;
        end
    end

    assign hit = $signed(r_vel) <= $signed(tbl_rdata.vel);

    always_comb begin
        case (r_fld)
            FLD_FREQ: begin
                lerp_a = $signed((FREQ_W + 1)'(r_lo.freq));
                lerp_b = $signed((FREQ_W + 1)'(r_hi.freq));
            end
            FLD_PERIOD: begin
                lerp_a = $signed((FREQ_W + 1)'(r_lo.period));
                lerp_b = $signed((FREQ_W + 1)'(r_hi.period));
            end
            default: begin
                lerp_a = $signed((FREQ_W + 1)'(r_lo.duty));
                lerp_b = $signed((FREQ_W + 1)'(r_hi.duty));
            end
        endcase
    end

    assign lerp_diff = lerp_b - lerp_a;
    assign lerp_mag  = lerp_diff[FREQ_W] ? -lerp_diff : lerp_diff;
    assign lerp_res  = r_neg ? (lerp_a - $signed({1'b0, md_stat.quot}))
                             : (lerp_a + $signed({1'b0, md_stat.quot}));
    assign on_q      = md_stat.quot;
    assign period_x  = FREQ_W'(r_period);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && !i_action) begin
                    n_state = (n_mode == MODE_SILENT) ? ST_OUT : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    n_state = (r_idx == '0) ? ST_ON_GO : ST_LERP_GO;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_ON_GO;
                end
            end
            ST_LERP_GO: begin
                n_state = ST_LERP_WAIT;
            end
            ST_LERP_WAIT: begin
                if (md_stat.done) begin
                    n_state = (r_fld == FLD_DUTY) ? ST_ON_GO : ST_LERP_GO;
                end
            end
            ST_ON_GO: begin
                n_state = ST_ON_WAIT;
            end
            ST_ON_WAIT: begin
                if (md_stat.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_cfg_ready = (r_state == ST_IDLE);
        tbl_we      = 1'b0;
        tbl_raddr   = '0;
        md_start    = 1'b0;
        md_req.mag  = lerp_mag[FREQ_W-1:0];
        md_req.mult = r_num;
        md_req.div  = r_den;
        case (r_state)
            ST_IDLE: begin
                tbl_we = in_accept && i_action
                         && (32'(i_entry_index) < 32'(TABLE_ENTRIES));
            end
            ST_SEARCH: begin
                tbl_raddr = r_idx + 1'b1;
            end
            ST_LERP_GO: begin
                md_start = 1'b1;
            end
            ST_ON_GO: begin
                md_start    = 1'b1;
                md_req.mag  = MD_QW'(r_period);
                md_req.mult = MD_MW'(r_duty);
                md_req.div  = PERCENT;
            end
            default: begin
                md_start = 1'b0;
            end
        endcase
    end

    assign tbl_wdata.vel    = i_entry_velocity;
    assign tbl_wdata.freq   = i_entry_freq;
    assign tbl_wdata.period = i_entry_period;
    assign tbl_wdata.duty   = i_entry_duty;

    vct_table u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (TBL_AW'(i_entry_index)),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    vct_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_req   (md_req),
        .o_stat  (md_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_SILENT;
            r_sink      <= SINK_RESET;
            r_climb     <= CLIMB_RESET;
            r_sens      <= SENS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept && !i_action) begin
                r_mode <= n_mode;
            end
            if (cfg_accept) begin
                case (i_cfg_index)
                    CFG_SINK:  r_sink  <= $signed(i_cfg_data[VEL_W-1:0]);
                    CFG_CLIMB: r_climb <= $signed(i_cfg_data[VEL_W-1:0]);
                    CFG_SENS:  r_sens  <= i_cfg_data[SENS_W-1:0];
                    default:   r_sens  <= r_sens;
                endcase
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_accept && !i_action) begin
                    r_vel <= i_velocity;
                    r_vol <= i_volume;
                    r_idx <= '0;
                end
            end
            ST_SEARCH: begin
                if (hit && r_idx != '0) begin
                    r_lo  <= r_prev;
                    r_hi  <= tbl_rdata;
                    r_fld <= FLD_FREQ;
                    r_num <= MD_MW'(r_vel - r_prev.vel);
                    r_den <= MD_MW'(tbl_rdata.vel - r_prev.vel);
                end else if (hit || r_idx == LAST_IDX) begin
                    r_freq   <= tbl_rdata.freq;
                    r_period <= tbl_rdata.period;
                    r_duty   <= tbl_rdata.duty;
                end else begin
                    r_prev <= tbl_rdata;
                    r_idx  <= r_idx + 1'b1;
                end
            end
            ST_LERP_GO: begin
                r_neg <= lerp_diff[FREQ_W];
            end
            ST_LERP_WAIT: begin
                if (md_stat.done) begin
                    case (r_fld)
                        FLD_FREQ: begin
                            r_freq <= lerp_res[FREQ_W-1:0];
                            r_fld  <= FLD_PERIOD;
                        end
                        FLD_PERIOD: begin
                            r_period <= lerp_res[PERIOD_W-1:0];
                            r_fld    <= FLD_DUTY;
                        end
                        default: begin
                            r_duty <= lerp_res[DUTY_W-1:0];
                        end
                    endcase
                end
            end
            ST_ON_WAIT: begin
                if (md_stat.done) begin
                    if (on_q == period_x || r_period == '0) begin
                        r_on   <= CONT_LENGTH;
                        r_off  <= CONT_LENGTH;
                        r_cont <= 1'b1;
                    end else begin
                        r_off  <= (on_q < period_x) ? PERIOD_W'(period_x - on_q) : '0;
                        r_on   <= (on_q > FREQ_W'(ON_MAX)) ? ON_MAX : on_q[PERIOD_W-1:0];
                        r_cont <= 1'b0;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_mode <= r_mode;
                    if (r_mode == MODE_SILENT) begin
                        r_out_freq <= '0;
                        r_out_on   <= '0;
                        r_out_off  <= '0;
                        r_out_cont <= 1'b0;
                        r_out_vol  <= '0;
                    end else begin
                        r_out_freq <= r_freq;
                        r_out_on   <= r_on;
                        r_out_off  <= r_off;
                        r_out_cont <= r_cont;
                        r_out_vol  <= r_vol;
                    end
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_mode       = r_out_mode;
    assign o_tone_freq  = r_out_freq;
    assign o_on_length  = r_out_on;
    assign o_off_length = r_out_off;
    assign o_continuous = r_out_cont;
    assign o_out_volume = r_out_vol;

    `VCT_ASSERT_IMP(a_md_start_idle, i_clk, i_rst_n, md_start, (!md_stat.busy), "multiply-divide started while busy")
    `VCT_ASSERT_NXT(a_write_one_cycle, i_clk, i_rst_n, (in_accept && i_action), (r_state == ST_IDLE), "table write did not return to idle")
    `VCT_ASSERT_IMP(a_search_sounding, i_clk, i_rst_n, (r_state == ST_SEARCH), (r_mode != MODE_SILENT), "table search in silent mode")
    `VCT_ASSERT_IMP(a_silent_mute, i_clk, i_rst_n, (r_out_valid && r_out_mode == MODE_SILENT), (r_out_freq == '0 && r_out_vol == '0 && !r_out_cont), "silent result not mute")

endmodule

>>> dv/vario_climb_tone_select_tb.sv
// Self-checking testbench for vario_climb_tone_select: a directed table, then random phases.
// Needs vct_pkg and the block's sources. Expected tones come from an in-bench predictor or directed rows.
`timescale 1ns / 1ps

module vario_climb_tone_select_tb;
    import vct_pkg::*;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_ENTRY  = 1'b1;
    localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;

    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 140;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic                    action;
        logic signed [VEL_W-1:0] vel;
        logic [VOL_W-1:0]        vol;
        logic [IDX_W-1:0]        idx;
        logic signed [VEL_W-1:0] evel;
        logic [FREQ_W-1:0]       efreq;
        logic [PERIOD_W-1:0]     eperiod;
        logic [DUTY_W-1:0]       eduty;
    } t_item;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [FREQ_W-1:0]   freq;
        logic [PERIOD_W-1:0] on_len;
        logic [PERIOD_W-1:0] off_len;
        logic                cont;
        logic [VOL_W-1:0]    vol;
    } t_tone;

    typedef struct {
        t_item item;
        bit    typed;
        t_tone want;
    } t_dir_row;

    localparam t_tone MUTE_TONE = '0;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_action;
    logic signed [VEL_W-1:0]   i_velocity;
    logic [VOL_W-1:0]          i_volume;
    logic [IDX_W-1:0]          i_entry_index;
    logic signed [VEL_W-1:0]   i_entry_velocity;
    logic [FREQ_W-1:0]         i_entry_freq;
    logic [PERIOD_W-1:0]       i_entry_period;
    logic [DUTY_W-1:0]         i_entry_duty;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [MODE_W-1:0]         o_mode;
    logic [FREQ_W-1:0]         o_tone_freq;
    logic [PERIOD_W-1:0]       o_on_length;
    logic [PERIOD_W-1:0]       o_off_length;
    logic                      o_continuous;
    logic [VOL_W-1:0]          o_out_volume;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IW-1:0]         i_cfg_index;
    logic [CFG_DW-1:0]         i_cfg_data;

    vario_climb_tone_select u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_velocity       (i_velocity),
        .i_volume         (i_volume),
        .i_entry_index    (i_entry_index),
        .i_entry_velocity (i_entry_velocity),
        .i_entry_freq     (i_entry_freq),
        .i_entry_period   (i_entry_period),
        .i_entry_duty     (i_entry_duty),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_mode           (o_mode),
        .o_tone_freq      (o_tone_freq),
        .o_on_length      (o_on_length),
        .o_off_length     (o_off_length),
        .o_continuous     (o_continuous),
        .o_out_volume     (o_out_volume),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: hysteresis mode, tone table and register copies.
    t_beep_mode beep_mode;
    int         tbl_vel    [TABLE_ENTRIES];
    int         tbl_freq   [TABLE_ENTRIES];
    int         tbl_period [TABLE_ENTRIES];
    int         tbl_duty   [TABLE_ENTRIES];
    int         cfg_sink;
    int         cfg_climb;
    int         cfg_sens;

    t_tone      pending_tones [$];
    t_dir_row   dir_rows [$];

    int n_samples   = 0;
    int n_entries   = 0;
    int n_results   = 0;
    int n_cfg       = 0;
    int errors      = 0;
    int idle_cycles = 0;
    int hold_cycles = 0;
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;

    function automatic int interp(input int a, input int b, input int num, input int den);
        longint prod;
        prod = longint'(b - a) * longint'(num);
        if (den <= 0)
            return a;
        return a + int'(prod / den);
    endfunction

    function automatic bit select_tone(input t_item it, output t_tone r);
        int v;
        int k;
        int num;
        int den;
        int freq;
        int period;
        int duty;
        int on_len;
        int off_len;
        bit leave;
        r = '0;
        if (it.action == ACT_ENTRY) begin
            tbl_vel[it.idx]    = $signed(it.evel);
            tbl_freq[it.idx]   = it.efreq;
            tbl_period[it.idx] = it.eperiod;
            tbl_duty[it.idx]   = it.eduty;
            return 1'b0;
        end
        v = $signed(it.vel);
        case (beep_mode)
            MODE_SINK:  leave = (cfg_sink + cfg_sens) < v;
            MODE_CLIMB: leave = v < (cfg_climb - cfg_sens);
            default:    leave = (v <= cfg_sink) || (cfg_climb <= v);
        endcase
        if (leave) begin
            if (v <= cfg_sink)
                beep_mode = MODE_SINK;
            else if (cfg_climb <= v)
                beep_mode = MODE_CLIMB;
            else
                beep_mode = MODE_SILENT;
        end
        r.mode = beep_mode;
        if (beep_mode == MODE_SILENT)
            return 1'b1;

        k = 0;
        while (k < TABLE_ENTRIES && v > tbl_vel[k])
            k++;
        if (k == 0 || k == TABLE_ENTRIES) begin
            if (k != 0)
                k--;
            freq   = tbl_freq[k];
            period = tbl_period[k];
            duty   = tbl_duty[k];
        end else begin
            num    = v - tbl_vel[k-1];
            den    = tbl_vel[k] - tbl_vel[k-1];
            freq   = interp(tbl_freq[k-1], tbl_freq[k], num, den);
            period = interp(tbl_period[k-1], tbl_period[k], num, den);
            duty   = interp(tbl_duty[k-1], tbl_duty[k], num, den);
        end

        on_len = (period * duty) / 100;
        if (period == on_len || period == 0) begin
            on_len  = 100;
            off_len = 100;
            r.cont  = 1'b1;
        end else begin
            off_len = (on_len < period) ? period - on_len : 0;
            if (on_len > 8191)
                on_len = 8191;
            r.cont = 1'b0;
        end
        r.freq    = freq[FREQ_W-1:0];
        r.on_len  = on_len[PERIOD_W-1:0];
        r.off_len = off_len[PERIOD_W-1:0];
        r.vol     = it.vol;
        return 1'b1;
    endfunction

    function automatic string show_tone(input t_tone t);
        return $sformatf("mode=%0d freq=%0d on=%0d off=%0d cont=%0d vol=%0d",
                         t.mode, t.freq, t.on_len, t.off_len, t.cont, t.vol);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR: %s", msg);
    endtask

    function automatic t_dir_row sample_row(input int v, input int vol, input bit typed,
                                            input t_tone want);
        t_dir_row r;
        r.item        = '0;
        r.item.action = ACT_SAMPLE;
        r.item.vel    = v[VEL_W-1:0];
        r.item.vol    = vol[VOL_W-1:0];
        r.typed       = typed;
        r.want        = want;
        return r;
    endfunction

    function automatic t_dir_row entry_row(input int idx, input int ev, input int f,
                                           input int p, input int d);
        t_dir_row r;
        r.item         = '0;
        r.item.action  = ACT_ENTRY;
        r.item.idx     = idx[IDX_W-1:0];
        r.item.evel    = ev[VEL_W-1:0];
        r.item.efreq   = f[FREQ_W-1:0];
        r.item.eperiod = p[PERIOD_W-1:0];
        r.item.eduty   = d[DUTY_W-1:0];
        r.typed        = 1'b0;
        r.want         = MUTE_TONE;
        return r;
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_tone typed_want);
        int    gap;
        t_tone r;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_action         <= it.action;
        i_velocity       <= it.vel;
        i_volume         <= it.vol;
        i_entry_index    <= it.idx;
        i_entry_velocity <= it.evel;
        i_entry_freq     <= it.efreq;
        i_entry_period   <= it.eperiod;
        i_entry_duty     <= it.eduty;
        do @(posedge i_clk); while (o_in_stall);
        if (select_tone(it, r))
            pending_tones.push_back(typed ? typed_want : r);
        if (it.action == ACT_ENTRY)
            n_entries++;
        else
            n_samples++;
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SINK:  cfg_sink  = $signed(data);
            CFG_CLIMB: cfg_climb = $signed(data);
            CFG_SENS:  cfg_sens  = data[SENS_W-1:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_tones.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int count);
        int         vals [TABLE_ENTRIES];
        int         lo;
        int         span;
        int         k;
        int         j;
        int         tmp;
        int         v;
        int         off;
        logic [95:0] noise;
        t_item      it;
        lo   = $urandom_range(0, 3000);
        lo   = lo - 2048;
        span = $urandom_range(15, 2047 - lo);
        for (k = 0; k < TABLE_ENTRIES; k++) begin
            off     = $urandom_range(0, span);
            vals[k] = lo + off;
        end
        for (k = 1; k < TABLE_ENTRIES; k++) begin
            tmp = vals[k];
            j   = k;
            while (j > 0 && vals[j-1] > tmp) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = tmp;
        end
        if ($urandom_range(0, 3) == 0) begin
            k       = $urandom_range(1, TABLE_ENTRIES - 1);
            vals[k] = vals[k-1];
        end

        // A fresh sorted table, then samples mixed with stray single-entry writes.
        for (k = 0; k < TABLE_ENTRIES; k++) begin
            noise     = {$urandom, $urandom, $urandom};
            it        = noise[$bits(t_item)-1:0];
            it.action = ACT_ENTRY;
            it.idx    = k[IDX_W-1:0];
            it.evel   = vals[k][VEL_W-1:0];
            it.efreq  = $urandom_range(0, 32767);
            case ($urandom_range(0, 7))
                0:       it.eperiod = '0;
                1:       it.eperiod = 8191 - $urandom_range(0, 200);
                default: it.eperiod = $urandom_range(1, 5000);
            endcase
            case ($urandom_range(0, 7))
                0:       it.eduty = 7'd100;
                1:       it.eduty = $urandom_range(101, 127);
                default: it.eduty = $urandom_range(0, 100);
            endcase
            send_item(it, 1'b0, MUTE_TONE);
        end

        repeat (count) begin
            noise = {$urandom, $urandom, $urandom};
            it    = noise[$bits(t_item)-1:0];
            if ($urandom_range(0, 7) == 0) begin
                it.action = ACT_ENTRY;
            end else begin
                it.action = ACT_SAMPLE;
                case ($urandom_range(0, 9))
                    0, 1: v = $signed(it.vel);
                    2, 3: begin
                        off = $urandom_range(0, 2 * cfg_sens + 40);
                        v   = cfg_sink - cfg_sens - 20 + off;
                    end
                    4, 5: begin
                        off = $urandom_range(0, 2 * cfg_sens + 40);
                        v   = cfg_climb - cfg_sens - 20 + off;
                    end
                    default: begin
                        off = $urandom_range(0, span + 120);
                        v   = lo - 60 + off;
                    end
                endcase
                if (v < -2048)
                    v = -2048;
                if (v > 2047)
                    v = 2047;
                it.vel = v[VEL_W-1:0];
            end
            send_item(it, 1'b0, MUTE_TONE);
        end
    endtask

    // Result side: a random hold-off before each transfer unless calm, and one long hold when asked.
    initial begin : result_sink
        int n;
        i_out_stall <= 1'b0;
        forever begin
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            n = rx_calm ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : tone_check
        t_tone got;
        t_tone want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_mode, o_tone_freq, o_on_length, o_off_length, o_continuous, o_out_volume};
            n_results++;
            if (pending_tones.size() == 0) begin
                flag_error($sformatf("result %0d arrived with none expected: %s",
                                     n_results, show_tone(got)));
            end else begin
                want = pending_tones.pop_front();
                if (got.mode != want.mode || got.freq != want.freq
                    || got.on_len != want.on_len || got.off_len != want.off_len
                    || got.cont != want.cont || got.vol != want.vol)
                    flag_error($sformatf("result %0d: expected %s, got %s",
                                         n_results, show_tone(want), show_tone(got)));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("No transfer for %0d cycles, giving up.", WATCHDOG_LIMIT);
            $display("vario_climb_tone_select_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        int ph;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_action         <= ACT_SAMPLE;
        i_velocity       <= '0;
        i_volume         <= '0;
        i_entry_index    <= '0;
        i_entry_velocity <= '0;
        i_entry_freq     <= '0;
        i_entry_period   <= '0;
        i_entry_duty     <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_SINK;
        i_cfg_data       <= '0;

        beep_mode = MODE_SILENT;
        cfg_sink  = SINK_RESET;
        cfg_climb = CLIMB_RESET;
        cfg_sens  = SENS_RESET;
        for (k = 0; k < TABLE_ENTRIES; k++) begin
            tbl_vel[k]    = 0;
            tbl_freq[k]   = 0;
            tbl_period[k] = 0;
            tbl_duty[k]   = 0;
        end

        // Silent samples are safe before the table is loaded; sounding ones are not.
        dir_rows.push_back(sample_row(0, 127, 1'b1, MUTE_TONE));
        dir_rows.push_back(sample_row(-299, 0, 1'b1, MUTE_TONE));
        for (k = 0; k < TABLE_ENTRIES; k++) begin
            case (k)
                0:  dir_rows.push_back(entry_row(k, -1600, 32767, 0, 0));
                4:  dir_rows.push_back(entry_row(k, -1000, 1400, 700, 40));
                14: dir_rows.push_back(entry_row(k, 1200, 2400, 1000, 100));
                15: dir_rows.push_back(entry_row(k, 1400, 0, 8191, 127));
                default: dir_rows.push_back(entry_row(k, -1600 + 200 * k, 1000 + 100 * k,
                                                      500 + 50 * k, 20 + 5 * k));
            endcase
        end
        dir_rows.push_back(sample_row(-2048, 100, 1'b1,
                                      {MODE_SINK, 15'd32767, CONT_LENGTH, CONT_LENGTH,
                                       1'b1, 7'd100}));
        dir_rows.push_back(sample_row(-1000, 55, 1'b0, MUTE_TONE));
        dir_rows.push_back(sample_row(-300, 1, 1'b0, MUTE_TONE));
        dir_rows.push_back(sample_row(-289, 64, 1'b1, MUTE_TONE));
        dir_rows.push_back(sample_row(20, 127, 1'b0, MUTE_TONE));
        dir_rows.push_back(sample_row(10, 3, 1'b0, MUTE_TONE));
        dir_rows.push_back(sample_row(1200, 90, 1'b0, MUTE_TONE));
        dir_rows.push_back(sample_row(2047, 100, 1'b1,
                                      {MODE_CLIMB, 15'd0, ON_MAX, 13'd0, 1'b0, 7'd100}));
        dir_rows.push_back(sample_row(9, 77, 1'b1, MUTE_TONE));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            tx_calm = (ph == 2);
            rx_calm = (ph == 2 || ph == 5);
            case (ph)
                1: begin
                    write_reg(CFG_SINK, 12'h800);
                    write_reg(CFG_CLIMB, 12'h7FF);
                    write_reg(CFG_SENS, 12'd0);
                end
                2: begin
                    write_reg(CFG_SINK, 12'h7FF);
                    write_reg(CFG_CLIMB, 12'h800);
                    write_reg(CFG_SENS, 12'h1FF);
                    write_reg(CFG_UNUSED, $urandom);
                end
                3: begin
                    write_reg(CFG_SINK, -12'sd600);
                    write_reg(CFG_CLIMB, 12'd150);
                    write_reg(CFG_SENS, 12'd40);
                    hold_cycles = HOLD_CYCLES;
                end
                4: begin
                    write_reg(CFG_SENS, $urandom);
                    write_reg(CFG_SINK, $urandom);
                    write_reg(CFG_CLIMB, $urandom);
                end
                5: begin
                    write_reg(CFG_SINK, -12'sd100 - $urandom_range(0, 400));
                    write_reg(CFG_CLIMB, $urandom_range(0, 400));
                    write_reg(CFG_SENS, $urandom_range(0, 120));
                end
                default: ;
            endcase
            i_cfg_valid <= 1'b0;
            run_phase(PHASE_ITEMS);
        end

        drain();
        errors += pending_tones.size();
        $display("Sent %0d velocity samples and %0d table writes; checked %0d tones.",
                 n_samples, n_entries, n_results);
        $display("Made %0d register writes over %0d phases; %0d errors.", n_cfg, PHASES, errors);
        if (errors == 0)
            $display("vario_climb_tone_select_tb: PASS");
        else
            $display("vario_climb_tone_select_tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/vct_pkg.sv
src/vct_table.sv
src/vct_muldiv.sv
src/vario_climb_tone_select.sv
dv/vario_climb_tone_select_tb.sv
